### hw/rtl/lnse_pkg.sv
`timescale 1ns / 1ps

package lnse_pkg;

	// frame geometry
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 13;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// result fields
	localparam int ACC_W      = 37;
	localparam int SIGMA_W    = 18;
	localparam int OUT_W      = ACC_W + SIGMA_W;
	localparam int TDATA_W    = ((OUT_W + 7) / 8) * 8;
	localparam logic [SIGMA_W-1:0] SIGMA_MAX = '1;

	// sqrt(pi/2) in Q24
	localparam int K_W        = 25;
	localparam logic [K_W-1:0] SQRT_HALF_PI_Q24 = K_W'(21027122);

	// sigma datapath
	localparam int LO_W       = 19;
	localparam int HI_W       = ACC_W - LO_W;
	localparam int NUM_W      = ACC_W + K_W;
	localparam int FRAC_SHIFT = 16;
	localparam int REM_W      = NUM_W - FRAC_SHIFT;
	localparam int DEN_W      = COL_W + ROW_W + 3;
	localparam int DSH_W      = DEN_W + SIGMA_W - 1;
	localparam int STEP_W     = $clog2(SIGMA_W);

	// frame queue, depth a power of two
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	// register map
	localparam int REG_IDX_W  = 1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} frame_result_t;

endpackage

### hw/rtl/lnse_fifo.sv
`timescale 1ns / 1ps

module lnse_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  lnse_pkg::frame_result_t push_data,
	input  logic                    pop,
	output lnse_pkg::frame_result_t pop_data,
	output logic                    not_empty
);
	import lnse_pkg::*;

	frame_result_t     entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign not_empty = (cnt_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < QCNT_W'(QDEPTH)) || pop)
		else $error("frame queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("frame queue read while empty");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) || (cnt_q == QCNT_W'(QDEPTH)) |-> wr_ptr_q == rd_ptr_q)
		else $error("frame queue pointers out of step with count");

endmodule

### hw/rtl/lnse_front.sv
`timescale 1ns / 1ps

module lnse_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [lnse_pkg::DIM_W-1:0] frame_width,
	input  logic [lnse_pkg::DIM_W-1:0] frame_height,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [lnse_pkg::PIX_W-1:0] s_axis_tdata,
	output logic                      q_push,
	output lnse_pkg::frame_result_t   q_push_data,
	input  logic                      q_pop
);
	import lnse_pkg::*;

	localparam int V_W = PIX_W + 3;
	localparam int R_W = V_W + 1;
	localparam int A_W = R_W - 1;

	function automatic logic [DIM_W-1:0] clamp_dim(
		input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] lim
	);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > lim)
			r = lim;
		return r;
	endfunction

	// line stores: a holds the previous row, b the one before
	logic [PIX_W-1:0] store_a [MAX_WIDTH];
	logic [PIX_W-1:0] store_b [MAX_WIDTH];

	logic [DIM_W-1:0]  w_eff, h_eff;
	logic [DIM_W-1:0]  col_nxt, row_nxt;
	logic              in_acc, row_end, frame_end, interior;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [QCNT_W-1:0] pend_q;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  acc_nxt;

	logic              valid_s1, int_s1, end_s1;
	logic [PIX_W-1:0]  pix_s1, mid_s1, top_s1;
	logic [COL_W-1:0]  col_s1;
	logic [DIM_W-1:0]  w_s1, h_s1;
	logic signed [V_W-1:0] vcur;

	logic              valid_s2, int_s2, end_s2;
	logic [DIM_W-1:0]  w_s2, h_s2;
	logic signed [V_W-1:0] v0_s2, v1_s2, v2_s2;
	logic signed [V_W-1:0] vprev1_q, vprev2_q;
	logic signed [R_W-1:0] resp;
	logic signed [R_W-1:0] resp_abs;

	logic              valid_s3, int_s3, end_s3;
	logic [DIM_W-1:0]  w_s3, h_s3;
	logic [A_W-1:0]    a_s3;

	assign w_eff     = clamp_dim(frame_width, DIM_W'(MAX_WIDTH));
	assign h_eff     = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));
	assign col_nxt   = DIM_W'(col_q) + DIM_W'(1);
	assign row_nxt   = DIM_W'(row_q) + DIM_W'(1);
	assign row_end   = col_nxt >= w_eff;
	assign frame_end = row_end && (row_nxt >= h_eff);
	assign interior  = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));

	// a request is taken only while every frame end in flight has a queue slot
	assign s_axis_tready = pend_q < QCNT_W'(QDEPTH);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// vertical pass of the separable kernel: top - 2*mid + bottom
	assign vcur = $signed({3'b000, top_s1}) + $signed({3'b000, pix_s1})
		- $signed({2'b00, mid_s1, 1'b0});

	// horizontal pass over three column sums
	assign resp = R_W'(v2_s2) + R_W'(v0_s2) - (R_W'(v1_s2) <<< 1);
	assign resp_abs = resp[R_W-1] ? -resp : resp;

	assign acc_nxt = acc_q + (int_s3 ? ACC_W'(a_s3) : '0);

	assign q_push             = valid_s3 && end_s3;
	assign q_push_data.sum    = acc_nxt;
	assign q_push_data.width  = w_s3;
	assign q_push_data.height = h_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			pend_q   <= '0;
			acc_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (in_acc) begin
				if (row_end) begin
					col_q <= '0;
					if (frame_end)
						row_q <= '0;
					else
						row_q <= row_nxt[ROW_W-1:0];
				end else begin
					col_q <= col_nxt[COL_W-1:0];
				end
			end
			if (in_acc && frame_end && !q_pop)
				pend_q <= pend_q + QCNT_W'(1);
			else if (q_pop && !(in_acc && frame_end))
				pend_q <= pend_q - QCNT_W'(1);
			if (valid_s3) begin
				if (end_s3)
					acc_q <= '0;
				else
					acc_q <= acc_nxt;
			end
		end
	end

	// line stores, read-after-write forwarded when a row is one pixel wide
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			store_a[col_s1] <= pix_s1;
			store_b[col_s1] <= mid_s1;
		end
		if (in_acc) begin
			if (valid_s1 && (col_s1 == col_q)) begin
				mid_s1 <= pix_s1;
				top_s1 <= mid_s1;
			end else begin
				mid_s1 <= store_a[col_q];
				top_s1 <= store_b[col_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= s_axis_tdata;
			col_s1 <= col_q;
			int_s1 <= interior;
			end_s1 <= frame_end;
			w_s1   <= w_eff;
			h_s1   <= h_eff;
		end
		if (valid_s1) begin
			v0_s2    <= vcur;
			v1_s2    <= vprev1_q;
			v2_s2    <= vprev2_q;
			vprev1_q <= vcur;
			vprev2_q <= vprev1_q;
			int_s2   <= int_s1;
			end_s2   <= end_s1;
			w_s2     <= w_s1;
			h_s2     <= h_s1;
		end
		if (valid_s2) begin
			a_s3   <= resp_abs[A_W-1:0];
			int_s3 <= int_s2;
			end_s3 <= end_s2;
			w_s3   <= w_s2;
			h_s3   <= h_s2;
		end
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= QCNT_W'(QDEPTH))
		else $error("more frame ends pending than queue slots");

	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && frame_end && !q_pop |=> pend_q == $past(pend_q) + QCNT_W'(1))
		else $error("frame end not reserved a queue slot");

	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> acc_q == '0)
		else $error("accumulator not cleared after frame end");

endmodule

### hw/rtl/lnse_back.sv
`timescale 1ns / 1ps

module lnse_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  lnse_pkg::frame_result_t     q_data,
	output logic                        q_pop,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [lnse_pkg::ACC_W-1:0]  residual_sum,
	output logic [lnse_pkg::SIGMA_W-1:0] sigma_q8
);
	import lnse_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_SAT  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]               state_q;
	logic [STEP_W-1:0]        step_q;
	logic                     m_valid_q;
	logic [ACC_W-1:0]         m_sum_q;
	logic [SIGMA_W-1:0]       m_sigma_q;

	logic [ACC_W-1:0]         sum_q;
	logic                     small_q;
	logic [COL_W-1:0]         dw_q;
	logic [ROW_W-1:0]         dh_q;
	logic [LO_W+K_W-1:0]      plo_q;
	logic [HI_W+K_W-1:0]      phi_q;
	logic [COL_W+ROW_W-1:0]   dprod_q;
	logic [DEN_W-1:0]         den_q;
	logic [REM_W-1:0]         rem_q;
	logic [DSH_W-1:0]         dsh_q;
	logic [SIGMA_W-1:0]       quo_q;

	logic [NUM_W-1:0]         num;
	logic [REM_W-1:0]         sat_lim;
	logic [REM_W-1:0]         dsh_ext;
	logic                     take;
	logic                     out_load;
	logic                     sat;

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
	assign num      = {phi_q, {LO_W{1'b0}}} + NUM_W'(plo_q);
	assign sat_lim  = REM_W'({den_q, {SIGMA_W{1'b0}}});
	assign sat      = rem_q >= sat_lim;
	assign dsh_ext  = REM_W'(dsh_q);
	assign take     = rem_q >= dsh_ext;

	assign m_axis_tvalid = m_valid_q;
	assign residual_sum  = m_sum_q;
	assign sigma_q8      = m_sigma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid)
						state_q <= ST_MUL1;
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_SAT;
				ST_SAT: begin
					step_q <= '0;
					if (small_q || sat)
						state_q <= ST_OUT;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SIGMA_W - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_sum_q   <= sum_q;
			m_sigma_q <= quo_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					sum_q   <= q_data.sum;
					small_q <= (q_data.width <= DIM_W'(2)) || (q_data.height <= DIM_W'(2));
					dw_q    <= COL_W'(q_data.width - DIM_W'(2));
					dh_q    <= ROW_W'(q_data.height - DIM_W'(2));
				end
			end
			ST_MUL1: begin
				plo_q <= sum_q[LO_W-1:0] * SQRT_HALF_PI_Q24;
			end
			ST_MUL2: begin
				phi_q   <= sum_q[ACC_W-1:LO_W] * SQRT_HALF_PI_Q24;
				dprod_q <= dw_q * dh_q;
			end
			ST_SUM: begin
				rem_q <= num[NUM_W-1:FRAC_SHIFT];
				den_q <= DEN_W'({dprod_q, 2'b00}) + DEN_W'({dprod_q, 1'b0});
			end
			ST_SAT: begin
				dsh_q <= {den_q, {(SIGMA_W - 1){1'b0}}};
				if (small_q)
					quo_q <= '0;
				else if (sat)
					quo_q <= SIGMA_MAX;
				else
					quo_q <= '0;
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				if (take)
					rem_q <= rem_q - dsh_ext;
				quo_q <= {quo_q[SIGMA_W-2:0], take};
				dsh_q <= dsh_q >> 1;
			end
			default: begin
			end
		endcase
	end

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < {1'b0, dsh_q, 1'b0})
		else $error("partial remainder out of range, quotient bit lost");

	a_small_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && small_q |=> sigma_q8 == '0)
		else $error("sigma not zero for a narrow frame");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> step_q < STEP_W'(SIGMA_W))
		else $error("division ran past its last step");

endmodule

### hw/rtl/laplacian_noise_sigma_estimator.sv
`timescale 1ns / 1ps

// Noise sigma estimator on the Laplacian residual of a gray frame.
// Pixels arrive on s_axis in raster order, one 8-bit pixel per request, and
// are taken at one per cycle while s_axis_tready is high. Frame size comes
// from the cfg channel (index 0 width, index 1 height, 1..4096; 0 reads as 1,
// larger as 4096); cfg_ready is always high and a write applies from the
// next pixel on. After the last pixel of a frame one result goes out on
// m_axis: the sum of absolute kernel responses over interior pixels and
// sigma in Q10.8. It passes the front pipeline, the frame queue and the
// MUL1, MUL2, SUM, SAT, DIV and OUT states; DIV is skipped when sigma is
// saturated or the frame is two pixels wide or high or less. The sigma unit
// takes a new frame only when idle (a restoring divider giving one quotient
// bit a cycle); a four-frame queue sits before it, so short frames can
// throttle s_axis_tready. Reset clears the counters and accumulator and sets
// 640 x 480; line store contents are kept, the first two rows of a frame
// read them but add nothing to the sum. While m_axis stalls the result stays
// held, the queue fills, and then s_axis_tready drops until a slot frees.

module laplacian_noise_sigma_estimator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [lnse_pkg::PIX_W-1:0]    s_axis_tdata,   // [7:0] pixel
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [lnse_pkg::TDATA_W-1:0]  m_axis_tdata,   // [36:0] residual_sum, [54:37] sigma_q8
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lnse_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [lnse_pkg::DIM_W-1:0]    cfg_data
);
	import lnse_pkg::*;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic               q_push;
	logic               q_pop;
	logic               q_valid;
	frame_result_t      q_push_data;
	frame_result_t      q_pop_data;
	logic [ACC_W-1:0]   residual_sum;
	logic [SIGMA_W-1:0] sigma_q8;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lnse_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_width  (width_q),
		.frame_height (height_q),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.q_push       (q_push),
		.q_push_data  (q_push_data),
		.q_pop        (q_pop)
	);

	lnse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.not_empty (q_valid)
	);

	lnse_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_pop_data),
		.q_pop        (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.residual_sum (residual_sum),
		.sigma_q8     (sigma_q8)
	);

	assign m_axis_tdata = {{(TDATA_W - OUT_W){1'b0}}, sigma_q8, residual_sum};

endmodule

### verif/tb_laplacian_noise_sigma_estimator.sv
`timescale 1ns / 1ps

module tb_laplacian_noise_sigma_estimator;

	import lnse_pkg::*;

	localparam longint unsigned ROOT_HALF_PI_Q24 = 64'd21027122;
	localparam longint unsigned SIGMA_CAP        = 64'd262143;
	localparam int              SETTLE_CYCLES    = 40;

	typedef struct {
		logic [ACC_W-1:0]   sum;
		logic [SIGMA_W-1:0] sigma;
	} frame_stats_t;

	typedef enum int {PAT_NOISE, PAT_EXTREME, PAT_RAMP, PAT_CHECKER, PAT_CHECKER_INV} pattern_t;
	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE} rx_style_t;

	// Tracks frame geometry and the residual accumulation, queues the per-frame
	// result that the block should emit.
	class sigma_tracker_t;
		bit   [PIX_W-1:0]   line_a [MAX_WIDTH];
		bit   [PIX_W-1:0]   line_b [MAX_WIDTH];
		logic [47:0]        win;
		int unsigned        col, row;
		logic [ACC_W-1:0]   acc;
		logic [DIM_W-1:0]   width_reg, height_reg;
		frame_stats_t       pending_frames[$];
		int                 errors;

		function new();
			win        = '0;
			col        = 0;
			row        = 0;
			acc        = '0;
			width_reg  = DIM_W'(640);
			height_reg = DIM_W'(480);
			errors     = 0;
		endfunction

		static function int unsigned size_used(input int unsigned v, input int unsigned cap);
			if (v == 0)
				return 1;
			else if (v > cap)
				return cap;
			else
				return v;
		endfunction

		static function int lap(input int a, input int b, input int c);
			return a - 2 * b + c;
		endfunction

		function void write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
			if (idx == REG_FRAME_WIDTH)
				width_reg = val;
			else
				height_reg = val;
		endfunction

		function logic [SIGMA_W-1:0] sigma_of(input logic [ACC_W-1:0] s, input int unsigned w,
				input int unsigned h);
			longint unsigned num, den, q;
			q = 0;
			if (w > 2 && h > 2) begin
				num = 64'(s) * ROOT_HALF_PI_Q24;
				den = 64'd6 * 64'(w - 2) * 64'(h - 2);
				q   = num / (den << 16);
				if (q > SIGMA_CAP)
					q = SIGMA_CAP;
			end
			return q[SIGMA_W-1:0];
		endfunction

		function void take_pixel(input logic [PIX_W-1:0] pix);
			int unsigned      w, h;
			logic [PIX_W-1:0] up1, up2;
			logic [23:0]      column, c0, c1;
			int               t, m, b, r;
			frame_stats_t     fr;
			w   = size_used(width_reg, MAX_WIDTH);
			h   = size_used(height_reg, MAX_HEIGHT);
			up1 = line_a[col];
			up2 = line_b[col];
			line_b[col] = up1;
			line_a[col] = pix;
			// oldest row in the top byte
			column = {up2, up1, pix};
			if (col >= 2 && row >= 2) begin
				c0 = win[47:24];
				c1 = win[23:0];
				t  = lap(c0[23:16], c1[23:16], column[23:16]);
				m  = lap(c0[15:8], c1[15:8], column[15:8]);
				b  = lap(c0[7:0], c1[7:0], column[7:0]);
				r  = t - 2 * m + b;
				if (r < 0)
					r = -r;
				acc = acc + ACC_W'(r);
			end
			win = {win[23:0], column};
			if (col + 1 >= w) begin
				col = 0;
				if (row + 1 >= h) begin
					fr.sum   = acc;
					fr.sigma = sigma_of(acc, w, h);
					pending_frames.insert(pending_frames.size(), fr);
					row = 0;
					acc = '0;
				end else begin
					row++;
				end
			end else begin
				col++;
			end
		endfunction

		function void check_frame_result(input logic [TDATA_W-1:0] word);
			frame_stats_t       want;
			logic [ACC_W-1:0]   got_sum;
			logic [SIGMA_W-1:0] got_sigma;
			got_sum   = word[ACC_W-1:0];
			got_sigma = word[ACC_W +: SIGMA_W];
			if (pending_frames.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: residual_sum %0d sigma_q8 %0d",
					$time, got_sum, got_sigma);
			end else begin
				want = pending_frames.pop_front();
				if (got_sum !== want.sum) begin
					errors++;
					$display("%0t: residual_sum expected %0d actual %0d",
						$time, want.sum, got_sum);
				end
				if (got_sigma !== want.sigma) begin
					errors++;
					$display("%0t: sigma_q8 expected %0d actual %0d",
						$time, want.sigma, got_sigma);
				end
			end
		endfunction

		function int pending();
			return pending_frames.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]    m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [REG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
	logic [DIM_W-1:0]      cfg_data = '0;

	sigma_tracker_t sb;
	int unsigned   burst_left = 0;
	int unsigned   hold_off_len = 0;
	int unsigned   pixels_sent = 0;
	int unsigned   frames_sent = 0;
	int unsigned   cols_used = 640;
	int unsigned   rows_used = 480;

	laplacian_noise_sigma_estimator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pixel before cfg: a write only applies from the next pixel
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.take_pixel(s_axis_tdata);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_frame_result(m_axis_tdata);
		end
	end

	initial begin : result_sink
		int unsigned seg_left, tick;
		rx_style_t   style;
		seg_left = 0;
		tick     = 0;
		style    = RX_ALWAYS;
		forever begin
			@(posedge clk);
			if (hold_off_len != 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_off_len) @(posedge clk);
				hold_off_len = 0;
			end else begin
				if (seg_left == 0) begin
					style    = rx_style_t'($urandom_range(0, 2));
					seg_left = $urandom_range(10, 150);
				end
				seg_left--;
				tick++;
				case (style)
					RX_ALWAYS: m_axis_tready <= 1'b1;
					RX_RANDOM: m_axis_tready <= ($urandom_range(0, 1) == 1);
					default:   m_axis_tready <= (tick % 5 == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		#(20_000_000);
		$display("simulation failed");
		$finish;
	end

	function automatic logic [PIX_W-1:0] make_pixel(input pattern_t style, input int unsigned x,
			input int unsigned y, input int unsigned base);
		case (style)
			PAT_NOISE:       return PIX_W'($urandom_range(0, 255));
			PAT_EXTREME:     return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
			PAT_RAMP:        return PIX_W'(x * 9 + y * 5 + base + $urandom_range(0, 3));
			PAT_CHECKER:     return ((x + y) % 2 == 0) ? 8'hFF : 8'h00;
			default:         return ((x + y) % 2 == 0) ? 8'h00 : 8'hFF;
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim(input int unsigned common_max);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return '0;
		else if (roll < 15)
			return DIM_W'($urandom_range(1, 2));
		else if (roll < 20)
			return DIM_W'($urandom_range(13, 40));
		else
			return DIM_W'($urandom_range(3, common_max));
	endfunction

	// bursty sender; valid stays up across a burst
	task automatic push_pixel(input logic [PIX_W-1:0] pix);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		pixels_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cols_used = sigma_tracker_t::size_used(w, MAX_WIDTH);
		rows_used = sigma_tracker_t::size_used(h, MAX_HEIGHT);
	endtask

	task automatic send_frame(input pattern_t style);
		int unsigned base;
		base = $urandom_range(0, 255);
		for (int unsigned y = 0; y < rows_used; y++)
			for (int unsigned x = 0; x < cols_used; x++)
				push_pixel(make_pixel(style, x, y, base));
		frames_sent++;
	endtask

	initial begin : stimulus
		logic [DIM_W-1:0] w, h;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// peak responses of both signs on the smallest interior frame
		program_size(DIM_W'(3), DIM_W'(3));
		send_frame(PAT_CHECKER);
		send_frame(PAT_CHECKER_INV);
		// zero width reads as one: every pixel closes a frame
		program_size('0, DIM_W'(1));
		push_pixel(8'h00);
		push_pixel(8'hFF);
		program_size(DIM_W'(2), DIM_W'(2));
		send_frame(PAT_NOISE);

		while (pixels_sent < 1450 || frames_sent < 40) begin
			w = pick_dim(12);
			h = pick_dim(10);
			program_size(w, h);
			repeat ($urandom_range(1, 3))
				send_frame(pattern_t'($urandom_range(0, 4)));
		end

		// receiver holds off long enough for the frame queue to back up
		program_size(DIM_W'(3), DIM_W'(3));
		hold_off_len = 800;
		repeat (25)
			send_frame(PAT_NOISE);

		drain();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
hw/rtl/lnse_pkg.sv
hw/rtl/lnse_fifo.sv
hw/rtl/lnse_front.sv
hw/rtl/lnse_back.sv
hw/rtl/laplacian_noise_sigma_estimator.sv
verif/tb_laplacian_noise_sigma_estimator.sv
